// ----- rtl/rkg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSA key generation package
// Shared widths, configuration register indexes, request and result types,
// and the controller state encoding.
// ----------------------------------------------------------------------------
package rkg_pkg;

	localparam int PRIME_BITS = 14;
	localparam int KEY_BITS   = 2 * PRIME_BITS;
	localparam int CNT_BITS   = $clog2(KEY_BITS);
	localparam int CFG_IDX_BITS = 1;

	localparam logic [CFG_IDX_BITS-1:0] CFG_PRIME_MIN = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_PRIME_MAX = 1'b1;

	localparam logic [PRIME_BITS-1:0] PRIME_MIN_RST = PRIME_BITS'(5000);
	localparam logic [PRIME_BITS-1:0] PRIME_MAX_RST = PRIME_BITS'(10000);

	typedef struct packed {
		logic [PRIME_BITS-1:0] prime_p;
		logic [PRIME_BITS-1:0] prime_q;
	} rkg_req_t;

	typedef struct packed {
		logic [KEY_BITS-1:0] modulus;
		logic [KEY_BITS-1:0] phi;
		logic [KEY_BITS-1:0] public_exp;
		logic [KEY_BITS-1:0] private_exp;
		logic                status;
	} rkg_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MN_GO,
		ST_MN_WAIT,
		ST_MP_GO,
		ST_MP_WAIT,
		ST_E_CHECK,
		ST_GCD_TEST,
		ST_GCD_WAIT,
		ST_INV_INIT,
		ST_INV_TEST,
		ST_INV_WAIT,
		ST_INV_MGO,
		ST_INV_MWAIT,
		ST_DONE
	} rkg_state_t;

endpackage

// ----- rtl/rsa_key_generation.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSA key generation
// Computes modulus, totient, public and private exponent from two primes.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// request   in         start / busy       req (prime_p, prime_q)
// result    out        done strobe        rsp (modulus .. status)
// config    in         cfg_we             cfg_idx, cfg_wdata
//
// A request takes two serial multiplies, then a Euclid gcd for each candidate
// exponent and finally an extended Euclid with one multiply after each division.
// Each multiply or division holds the controller in a wait state until its done
// strobe. Reset returns the limits to 5000 and 10000 and the controller to idle.
// The result strobe lasts one cycle and the receiver cannot stall it.
// ----------------------------------------------------------------------------
module rsa_key_generation
	import rkg_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  rkg_req_t                req,
	output logic                    done,
	output rkg_rsp_t                rsp,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_idx,
	input  logic [PRIME_BITS-1:0]   cfg_wdata
);

	rkg_state_t state_q, state_d;

	logic [PRIME_BITS-1:0] pmin_q, pmax_q;
	logic [PRIME_BITS-1:0] p_q, q_q;
	logic [KEY_BITS-1:0]   n_q, phi_q, e_q, d_q;
	logic [KEY_BITS-1:0]   ga_q, gb_q, r0_q, r1_q, t0_q, t1_q, quo_q, r2_q;
	logic                  neg_q, bad_q;

	logic                  mul_start, mul_done, div_start, div_done;
	logic [KEY_BITS-1:0]   mul_a, mul_b, mul_add, mul_prod;
	logic [KEY_BITS-1:0]   div_a, div_b, div_quot, div_rem;
	logic [KEY_BITS-1:0]   tm, d_fin;
	logic [PRIME_BITS-1:0] pd, qd;

	assign pd = (p_q != '0) ? p_q - 1'b1 : '0;
	assign qd = (q_q != '0) ? q_q - 1'b1 : '0;
	assign tm = (t1_q >= phi_q) ? t1_q - phi_q : t1_q;
	assign d_fin = (r1_q != KEY_BITS'(1)) ? '0 :
		((neg_q && tm != '0) ? phi_q - tm : tm);

	rkg_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mcand  (mul_a),
		.mplier (mul_b),
		.addend (mul_add),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	rkg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pmin_q  <= PRIME_MIN_RST;
			pmax_q  <= PRIME_MAX_RST;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_PRIME_MIN: pmin_q <= cfg_wdata;
					CFG_PRIME_MAX: pmax_q <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (start) state_d = ST_MN_GO;
			ST_MN_GO:     state_d = ST_MN_WAIT;
			ST_MN_WAIT:   if (mul_done) state_d = ST_MP_GO;
			ST_MP_GO:     state_d = ST_MP_WAIT;
			ST_MP_WAIT:   if (mul_done) state_d = ST_E_CHECK;
			ST_E_CHECK:   state_d = (e_q < phi_q) ? ST_GCD_TEST : ST_INV_INIT;
			ST_GCD_TEST: begin
				if (gb_q != '0) begin
					state_d = ST_GCD_WAIT;
				end else begin
					state_d = (ga_q == KEY_BITS'(1)) ? ST_INV_INIT : ST_E_CHECK;
				end
			end
			ST_GCD_WAIT:  if (div_done) state_d = ST_GCD_TEST;
			ST_INV_INIT:  state_d = (phi_q < KEY_BITS'(2)) ? ST_DONE : ST_INV_TEST;
			ST_INV_TEST:  state_d = (r1_q > KEY_BITS'(1)) ? ST_INV_WAIT : ST_DONE;
			ST_INV_WAIT:  if (div_done) state_d = ST_INV_MGO;
			ST_INV_MGO:   state_d = ST_INV_MWAIT;
			ST_INV_MWAIT: if (mul_done) state_d = ST_INV_TEST;
			ST_DONE:      state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy      = (state_q != ST_IDLE);
		done      = (state_q == ST_DONE);
		mul_start = 1'b0;
		div_start = 1'b0;
		mul_a     = {{PRIME_BITS{1'b0}}, p_q};
		mul_b     = {{PRIME_BITS{1'b0}}, q_q};
		mul_add   = '0;
		div_a     = ga_q;
		div_b     = gb_q;
		unique case (state_q)
			ST_MN_GO: mul_start = 1'b1;
			ST_MP_GO: begin
				mul_start = 1'b1;
				mul_a     = {{PRIME_BITS{1'b0}}, pd};
				mul_b     = {{PRIME_BITS{1'b0}}, qd};
			end
			ST_GCD_TEST: div_start = (gb_q != '0);
			ST_INV_TEST: begin
				div_start = (r1_q > KEY_BITS'(1));
				div_a     = r0_q;
				div_b     = r1_q;
			end
			ST_INV_MGO: begin
				mul_start = 1'b1;
				mul_a     = t1_q;
				mul_b     = quo_q;
				mul_add   = t0_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					p_q   <= req.prime_p;
					q_q   <= req.prime_q;
					e_q   <= KEY_BITS'(2);
					bad_q <= (req.prime_p < pmin_q) || (req.prime_p > pmax_q) ||
						(req.prime_q < pmin_q) || (req.prime_q > pmax_q);
				end
			end
			ST_MN_WAIT: if (mul_done) n_q <= mul_prod;
			ST_MP_WAIT: if (mul_done) phi_q <= mul_prod;
			ST_E_CHECK: begin
				ga_q <= phi_q;
				gb_q <= e_q;
			end
			ST_GCD_TEST: begin
				if (gb_q == '0 && ga_q != KEY_BITS'(1)) begin
					e_q <= e_q + 1'b1;
				end
			end
			ST_GCD_WAIT: begin
				if (div_done) begin
					ga_q <= gb_q;
					gb_q <= div_rem;
				end
			end
			ST_INV_INIT: begin
				d_q   <= '0;
				r0_q  <= phi_q;
				r1_q  <= (e_q >= phi_q) ? e_q - phi_q : e_q;
				t0_q  <= '0;
				t1_q  <= KEY_BITS'(1);
				neg_q <= 1'b0;
			end
			ST_INV_TEST: if (r1_q <= KEY_BITS'(1)) d_q <= d_fin;
			ST_INV_WAIT: begin
				if (div_done) begin
					quo_q <= div_quot;
					r2_q  <= div_rem;
				end
			end
			ST_INV_MWAIT: begin
				if (mul_done) begin
					r0_q  <= r1_q;
					r1_q  <= r2_q;
					t0_q  <= t1_q;
					t1_q  <= mul_prod;
					neg_q <= !neg_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp.modulus     = n_q;
	assign rsp.phi         = phi_q;
	assign rsp.public_exp  = e_q;
	assign rsp.private_exp = d_q;
	assign rsp.status      = bad_q;

`ifndef ASSERT_OFF
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted request did not raise busy");
	a_units_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_start && div_start)) else $error("multiplier and divider started together");
`endif

endmodule

// ----- rtl/rkg_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rkg_div
	import rkg_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [KEY_BITS-1:0] dividend,
	input  logic [KEY_BITS-1:0] divisor,
	output logic                done,
	output logic [KEY_BITS-1:0] quot,
	output logic [KEY_BITS-1:0] rem
);

	localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(KEY_BITS - 1);

	logic                run_q;
	logic                done_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [KEY_BITS-1:0] quo_q;
	logic [KEY_BITS-1:0] rem_q;
	logic [KEY_BITS-1:0] dvs_q;
	logic [KEY_BITS:0]   shifted;
	logic [KEY_BITS:0]   trial;

	assign shifted = {rem_q, quo_q[KEY_BITS-1]};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			if (!trial[KEY_BITS]) begin
				rem_q <= trial[KEY_BITS-1:0];
				quo_q <= {quo_q[KEY_BITS-2:0], 1'b1};
			end else begin
				rem_q <= shifted[KEY_BITS-1:0];
				quo_q <= {quo_q[KEY_BITS-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

// ----- rtl/rkg_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial multiplier
// Shift-and-add multiply with addend, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module rkg_mul
	import rkg_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [KEY_BITS-1:0] mcand,
	input  logic [KEY_BITS-1:0] mplier,
	input  logic [KEY_BITS-1:0] addend,
	output logic                done,
	output logic [KEY_BITS-1:0] prod
);

	localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(KEY_BITS - 1);

	logic                run_q;
	logic                done_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [KEY_BITS-1:0] a_q;
	logic [KEY_BITS-1:0] b_q;
	logic [KEY_BITS-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= mcand;
			b_q   <= mplier;
			acc_q <= addend;
		end else if (run_q) begin
			a_q <= {a_q[KEY_BITS-2:0], 1'b0};
			b_q <= {1'b0, b_q[KEY_BITS-1:1]};
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule
